/* hw/rtl/plit_pkg.sv */
// package for the piecewise linear interpolation table
// types, status codes and controller states; no dependencies
`timescale 1ns / 1ps
package plit_pkg;
	localparam int unsigned DEPTH = 64;
	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned QW = 32;

	localparam logic [2:0] ST_LOAD_OK = 3'd0;
	localparam logic [2:0] ST_LOAD_FULL = 3'd1;
	localparam logic [2:0] ST_QUERY_OK = 3'd2;
	localparam logic [2:0] ST_OUT_OF_RANGE = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;
	localparam logic signed [15:0] ONE_Q412 = 16'sd4096;

	typedef enum logic [3:0] {
		S_IDLE, S_LSCAN, S_LSHIFT, S_LWRITE, S_QFIRST, S_QLAST, S_QSCAN,
		S_QPREV, S_QMUL, S_QDIV, S_QFIN, S_OUT
	} state_t;

	typedef struct packed {
		logic take;      // capture input item
		logic rd_cur;    // read entry at index
		logic rd_prev;   // read entry at index-1
		logic rd_first;
		logic rd_last;
		logic idx_dec;
		logic idx_inc;
		logic shift_wr;  // write entry idx from read data (shift up)
		logic ins_wr;    // write new point at idx
		logic mul;
		logic div_start;
		logic div_step;
		logic set_full;
		logic set_load;
		logic set_empty;
		logic set_oor;
		logic set_match;
		logic set_interp;
		logic out_valid;
	} cmd_t;

	typedef struct packed {
		logic is_query;
		logic full;
		logic empty;
		logic idx_zero;
		logic idx_at_cnt;
		logic rd_gt;     // stored angle > key
		logic rd_eq;
		logic rd_lt_key_below; // key < stored (for query scan)
		logic below_first;
		logic above_last;
		logic den_le0;
		logic div_done;
		logic out_taken;
	} stat_t;
endpackage

/* hw/rtl/plit_if.sv */
// valid/ready channel interfaces for the interpolation table
// depends on nothing
`timescale 1ns / 1ps
interface plit_in_if;
	logic valid;
	logic ready;
	logic mode;
	logic signed [15:0] angle;
	logic signed [15:0] point_value;
	modport source(output valid, mode, angle, point_value, input ready);
	modport sink(input valid, mode, angle, point_value, output ready);
endinterface

interface plit_out_if;
	logic valid;
	logic ready;
	logic signed [15:0] result_value;
	logic [2:0] status;
	modport source(output valid, result_value, status, input ready);
	modport sink(input valid, result_value, status, output ready);
endinterface

/* hw/rtl/piecewise_linear_interpolation_table.sv */
// top level of the piecewise linear interpolation table
// depends on plit_pkg, plit_if, plit_ctrl, plit_dp
//
//  channel   dir  payload
//  in_ch     in   mode, angle, point_value
//  out_ch    out  result_value, status
//
// one item at a time; a load moves each larger entry up one place and then
// writes the new point into the gap, and a query scans the entries and then,
// when it interpolates, runs a 32-step restoring divider
// reset clears the controller state and, in the datapath, only the entry count;
// stored breakpoints need no clearing; a result waits in its register until taken; input stays stalled meanwhile
`timescale 1ns / 1ps
module piecewise_linear_interpolation_table (
	input logic clk,
	input logic arst_n,
	plit_in_if.sink in_ch,
	plit_out_if.source out_ch
);
	plit_pkg::cmd_t cmd;
	plit_pkg::stat_t st;

	// sequencing of scan, shift and divide
	plit_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid),
		.st(st), .cmd(cmd), .in_ready(in_ch.ready)
	);

	// storage and arithmetic
	plit_dp u_dp (
		.clk(clk), .arst_n(arst_n), .in_mode(in_ch.mode), .in_angle(in_ch.angle),
		.in_point_value(in_ch.point_value), .out_ready(out_ch.ready),
		.cmd(cmd), .st(st), .result_value(out_ch.result_value), .status(out_ch.status)
	);

	assign out_ch.valid = cmd.out_valid;
endmodule

/* hw/rtl/plit_ctrl.sv */
// controller state machine for the interpolation table
// depends on plit_pkg
`timescale 1ns / 1ps
module plit_ctrl (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input plit_pkg::stat_t st,
	output plit_pkg::cmd_t cmd,
	output logic in_ready
);
	plit_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= plit_pkg::S_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			plit_pkg::S_IDLE: if (in_valid) state_d = plit_pkg::S_QFIRST;
			plit_pkg::S_QFIRST: begin
				if (!st.is_query) begin
					if (st.full) state_d = plit_pkg::S_OUT;
					else if (st.idx_zero) state_d = plit_pkg::S_LWRITE;
					else state_d = plit_pkg::S_LSCAN;
				end else if (st.empty) state_d = plit_pkg::S_OUT;
				else state_d = plit_pkg::S_QLAST;
			end
			plit_pkg::S_LSCAN: begin
				// entry idx-1 on read port
				if (st.rd_gt) state_d = plit_pkg::S_LSHIFT;
				else state_d = plit_pkg::S_LWRITE;
			end
			plit_pkg::S_LSHIFT: begin
				if (st.idx_zero) state_d = plit_pkg::S_LWRITE;
				else state_d = plit_pkg::S_LSCAN;
			end
			plit_pkg::S_LWRITE: state_d = plit_pkg::S_OUT;
			plit_pkg::S_QLAST: begin
				if (st.below_first || st.above_last) state_d = plit_pkg::S_OUT;
				else state_d = plit_pkg::S_QSCAN;
			end
			plit_pkg::S_QSCAN: begin
				if (st.rd_eq) state_d = plit_pkg::S_OUT;
				else if (st.rd_lt_key_below && !st.idx_zero) state_d = plit_pkg::S_QPREV;
				else if (st.idx_at_cnt) state_d = plit_pkg::S_OUT;
			end
			plit_pkg::S_QPREV: state_d = plit_pkg::S_QMUL;
			plit_pkg::S_QMUL: state_d = st.den_le0 ? plit_pkg::S_OUT : plit_pkg::S_QDIV;
			plit_pkg::S_QDIV: if (st.div_done) state_d = plit_pkg::S_QFIN;
			plit_pkg::S_QFIN: state_d = plit_pkg::S_OUT;
			plit_pkg::S_OUT: if (st.out_taken) state_d = plit_pkg::S_IDLE;
			default: state_d = plit_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		case (state_q)
			plit_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.take = in_valid;
			end
			plit_pkg::S_QFIRST: begin
				if (!st.is_query) begin
					if (st.full) cmd.set_full = 1'b1;
					else if (!st.idx_zero) cmd.rd_prev = 1'b1;
				end else if (st.empty) cmd.set_empty = 1'b1;
				else cmd.rd_last = 1'b1;
			end
			plit_pkg::S_LSCAN: begin
				// move entry idx-1 up and step down
				if (st.rd_gt) begin
					cmd.shift_wr = 1'b1;
					cmd.idx_dec = 1'b1;
				end
			end
			plit_pkg::S_LSHIFT: if (!st.idx_zero) cmd.rd_prev = 1'b1;
			plit_pkg::S_LWRITE: begin
				cmd.ins_wr = 1'b1;
				cmd.set_load = 1'b1;
			end
			plit_pkg::S_QLAST: begin
				if (st.below_first || st.above_last) cmd.set_oor = 1'b1;
				else cmd.rd_cur = 1'b1;
			end
			plit_pkg::S_QSCAN: begin
				if (st.rd_eq) cmd.set_match = 1'b1;
				else if (st.rd_lt_key_below && !st.idx_zero) cmd.rd_prev = 1'b1;
				else if (st.idx_at_cnt) cmd.set_oor = 1'b1;
				else begin
					cmd.idx_inc = 1'b1;
					cmd.rd_cur = 1'b1;
				end
			end
			plit_pkg::S_QPREV: cmd.mul = 1'b1;
			plit_pkg::S_QMUL: begin
				if (st.den_le0) cmd.set_match = 1'b1;
				else cmd.div_start = 1'b1;
			end
			plit_pkg::S_QDIV: cmd.div_step = 1'b1;
			plit_pkg::S_QFIN: cmd.set_interp = 1'b1;
			plit_pkg::S_OUT: cmd.out_valid = 1'b1;
			default: ;
		endcase
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == plit_pkg::S_IDLE) else $error("ready outside idle");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_valid && !st.out_taken |=> cmd.out_valid) else $error("result dropped");
	a_take_leaves: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take |=> state_q == plit_pkg::S_QFIRST) else $error("take not followed");
endmodule

/* hw/rtl/plit_dp.sv */
// datapath: breakpoint memory, scan index, multiplier and serial divider
// depends on plit_pkg
`timescale 1ns / 1ps
module plit_dp (
	input logic clk,
	input logic arst_n,
	input logic in_mode,
	input logic signed [15:0] in_angle,
	input logic signed [15:0] in_point_value,
	input logic out_ready,
	input plit_pkg::cmd_t cmd,
	output plit_pkg::stat_t st,
	output logic signed [15:0] result_value,
	output logic [2:0] status
);
	logic [31:0] mem [plit_pkg::DEPTH];
	logic [31:0] rd_q;
	logic signed [15:0] first_q;
	logic [plit_pkg::CW-1:0] cnt_q;
	logic [plit_pkg::CW-1:0] idx_q;
	logic mode_q;
	logic signed [15:0] key_q, val_q;
	logic signed [15:0] va_q, c_q, vc_q;
	logic signed [15:0] res_q;
	logic [2:0] status_q;
	logic signed [33:0] prod_q;
	logic [16:0] den_q;
	logic [plit_pkg::QW-1:0] quo_q, num_q;
	logic [16:0] rem_q;
	logic neg_q;
	logic [5:0] step_q;
	logic signed [15:0] rd_ang, rd_val, f_ang;
	logic [plit_pkg::AW-1:0] rd_addr;
	logic rd_en;
	logic [17:0] rem_sh;
	logic [plit_pkg::CW-1:0] idx_m1;
	logic signed [plit_pkg::QW:0] sq;

	assign rd_ang = rd_q[31:16];
	assign rd_val = rd_q[15:0];
	assign f_ang = first_q;
	assign idx_m1 = idx_q - 1'b1;

	always_comb begin
		rd_en = cmd.rd_cur | cmd.rd_prev | cmd.rd_last;
		rd_addr = idx_q[plit_pkg::AW-1:0];
		if (cmd.rd_prev) rd_addr = idx_m1[plit_pkg::AW-1:0];
		else if (cmd.rd_last) begin
			rd_addr = cnt_q[plit_pkg::AW-1:0] - 1'b1;
		end else if (cmd.rd_cur && cmd.idx_inc) begin
			rd_addr = idx_q[plit_pkg::AW-1:0] + 1'b1;
		end
	end

	// memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.shift_wr) mem[idx_q[plit_pkg::AW-1:0]] <= rd_q;
		else if (cmd.ins_wr) mem[idx_q[plit_pkg::AW-1:0]] <= {key_q, val_q};
		if (rd_en) rd_q <= mem[rd_addr];
		else if (cmd.take) rd_q <= mem[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cnt_q <= '0;
		else if (cmd.ins_wr) cnt_q <= cnt_q + 1'b1;
	end

	assign rem_sh = {rem_q, num_q[plit_pkg::QW-1]};

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q <= in_mode;
			key_q <= in_angle;
			val_q <= in_point_value;
			idx_q <= cnt_q;
		end
		if (cmd.rd_last) begin
			first_q <= rd_ang;
			idx_q <= '0;
		end
		if (cmd.idx_dec) idx_q <= idx_m1;
		if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		if (cmd.rd_prev && mode_q) begin
			c_q <= rd_ang;
			vc_q <= rd_val;
		end
		if (cmd.mul) begin
			va_q <= rd_val;
			prod_q <= 34'(($signed({key_q[15], key_q}) - $signed({rd_ang[15], rd_ang}))
				* ($signed({vc_q[15], vc_q}) - $signed({rd_val[15], rd_val})));
			den_q <= 17'($signed({c_q[15], c_q}) - $signed({rd_ang[15], rd_ang}));
		end
		if (cmd.div_start) begin
			neg_q <= prod_q[33];
			num_q <= prod_q[33] ? plit_pkg::QW'(-prod_q) : plit_pkg::QW'(prod_q);
			rem_q <= '0;
			quo_q <= '0;
			step_q <= '0;
		end
		if (cmd.div_step) begin
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= 17'(rem_sh - {1'b0, den_q});
				quo_q <= {quo_q[plit_pkg::QW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh[16:0];
				quo_q <= {quo_q[plit_pkg::QW-2:0], 1'b0};
			end
			num_q <= {num_q[plit_pkg::QW-2:0], 1'b0};
			step_q <= step_q + 1'b1;
		end
		if (cmd.set_full) begin res_q <= '0; status_q <= plit_pkg::ST_LOAD_FULL; end
		if (cmd.set_load) begin res_q <= '0; status_q <= plit_pkg::ST_LOAD_OK; end
		if (cmd.set_empty) begin res_q <= '0; status_q <= plit_pkg::ST_EMPTY; end
		if (cmd.set_oor) begin
			res_q <= plit_pkg::ONE_Q412;
			status_q <= plit_pkg::ST_OUT_OF_RANGE;
		end
		if (cmd.set_match) begin
			res_q <= st.den_le0 && !st.rd_eq ? va_q : rd_val;
			status_q <= plit_pkg::ST_QUERY_OK;
		end
		if (cmd.set_interp) begin
			res_q <= 16'(sq);
			status_q <= plit_pkg::ST_QUERY_OK;
		end
	end

	assign sq = neg_q ? -$signed({1'b0, quo_q}) + va_q : $signed({1'b0, quo_q}) + va_q;

	always_comb begin
		st = '0;
		st.is_query = mode_q;
		st.full = cnt_q >= plit_pkg::CW'(plit_pkg::DEPTH);
		st.empty = cnt_q == '0;
		st.idx_zero = mode_q ? (idx_q == '0) : (idx_q == '0);
		st.idx_at_cnt = (idx_q + 1'b1) >= cnt_q;
		st.rd_gt = rd_ang > key_q;
		st.rd_eq = rd_ang == key_q;
		st.rd_lt_key_below = key_q < rd_ang;
		st.below_first = key_q < f_ang;
		st.above_last = key_q > rd_ang;
		st.den_le0 = $signed(den_q) <= 0;
		st.div_done = step_q == 6'(plit_pkg::QW - 1);
		st.out_taken = out_ready;
	end

	assign result_value = res_q;
	assign status = status_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= plit_pkg::CW'(plit_pkg::DEPTH)) else $error("count overflow");
	a_ins_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ins_wr |=> cnt_q == $past(cnt_q) + 1'b1) else $error("count not bumped");
	a_no_dual_wr: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.shift_wr && cmd.ins_wr)) else $error("two writes");
endmodule

/* sim/piecewise_linear_interpolation_table_tb.sv */
// self-checking testbench for the piecewise linear interpolation table
// depends on plit_pkg, plit_if and the table rtl; the breakpoint table is mirrored in a class
`timescale 1ns / 1ps
module piecewise_linear_interpolation_table_tb;
	localparam int MAX_CYCLES = 400000;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	typedef struct {
		logic signed [15:0] value;
		logic [2:0] status;
	} answer_t;

	// mirror of the breakpoint table plus the queue of answers still owed
	class table_scoreboard;
		logic signed [15:0] angles[$];
		logic signed [15:0] values[$];
		answer_t owed[$];
		int errors;
		int loads;
		int queries;
		int interps;

		function void note_item(logic mode, logic signed [15:0] ang,
				logic signed [15:0] val);
			answer_t a;
			int pos;
			longint lo;
			longint hi;
			longint vlo;
			longint vhi;
			a.value = '0;
			if (mode == MODE_LOAD) begin
				loads++;
				if (angles.size() >= plit_pkg::DEPTH) begin
					a.status = plit_pkg::ST_LOAD_FULL;
				end else begin
					// new point goes after every point with angle <= its own
					pos = angles.size();
					while (pos > 0 && angles[pos - 1] > ang)
						pos--;
					angles.insert(pos, ang);
					values.insert(pos, val);
					a.status = plit_pkg::ST_LOAD_OK;
				end
			end else begin
				queries++;
				if (angles.size() == 0) begin
					a.status = plit_pkg::ST_EMPTY;
				end else if (ang < angles[0] || ang > angles[angles.size() - 1]) begin
					a.status = plit_pkg::ST_OUT_OF_RANGE;
					a.value = plit_pkg::ONE_Q412;
				end else begin
					a.status = plit_pkg::ST_QUERY_OK;
					for (int i = 0; i < angles.size(); i++) begin
						if (ang == angles[i]) begin
							a.value = values[i];
							break;
						end
						if (ang < angles[i]) begin
							lo = angles[i - 1];
							hi = angles[i];
							vlo = values[i - 1];
							vhi = values[i];
							// sv division truncates toward zero as required
							a.value = 16'(vlo + ((longint'(ang) - lo) * (vhi - vlo)) / (hi - lo));
							interps++;
							break;
						end
					end
				end
			end
			owed.insert(owed.size(), a);
		endfunction

		function void check_result(logic signed [15:0] val, logic [2:0] st);
			answer_t a;
			if (owed.size() == 0) begin
				$error("result with nothing outstanding: value %0d status %0d", val, st);
				errors++;
				return;
			end
			a = owed.pop_front();
			if (st !== a.status) begin
				$error("status: expected %0d, actual %0d", a.status, st);
				errors++;
			end
			if (val !== a.value) begin
				$error("result_value: expected %0d, actual %0d", a.value, val);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int cycles = 0;
	bit stim_done = 1'b0;
	bit calm = 1'b0;      // no idling on either side while set
	bit hold_off = 1'b0;  // receiver long stall request
	table_scoreboard board;

	plit_in_if in_ch();
	plit_out_if out_ch();

	piecewise_linear_interpolation_table u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.mode = MODE_LOAD;
		in_ch.angle = '0;
		in_ch.point_value = '0;
		out_ch.ready = 1'b0;
		board = new();
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= MAX_CYCLES) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				board.owed.size());
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver: random stalls, a long hold-off on request, none during calm
	always @(posedge clk) begin
		if (!arst_n)
			out_ch.ready <= 1'b0;
		else if (hold_off)
			out_ch.ready <= 1'b0;
		else if (calm)
			out_ch.ready <= 1'b1;
		else
			out_ch.ready <= ($urandom_range(99) >= 20);
		if (arst_n && out_ch.valid && out_ch.ready)
			board.check_result(out_ch.result_value, out_ch.status);
	end

	// one transfer on the input channel, with a random gap in front;
	// valid stays up after the transfer until the next gap or an explicit stop
	task automatic send_item(logic mode, logic signed [15:0] ang, logic signed [15:0] val);
		while (!calm && $urandom_range(99) < 20) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.mode <= mode;
		in_ch.angle <= ang;
		in_ch.point_value <= val;
		do
			@(posedge clk);
		while (!in_ch.ready);
		board.note_item(mode, ang, val);
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.owed.size() != 0)
			@(posedge clk);
	endtask

	// angles near the centre so that queries land inside the table often
	function automatic logic signed [15:0] pick_angle();
		case ($urandom_range(9))
		0: return 16'($urandom);
		1: return 16'sh8000;
		2: return 16'sh7fff;
		default: return 16'($signed(11'($urandom)));
		endcase
	endfunction

	initial begin
		int n;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty table, then extremes, duplicates and boundaries
		send_item(MODE_QUERY, 16'sd0, 16'sh7fff);
		send_item(MODE_LOAD, 16'sd0, 16'sh8000);
		send_item(MODE_QUERY, 16'sd0, 16'sd0);
		send_item(MODE_QUERY, 16'sd1, 16'sd0);
		send_item(MODE_QUERY, -16'sd1, 16'sd0);
		send_item(MODE_LOAD, 16'sh7fff, 16'sh7fff);
		send_item(MODE_LOAD, 16'sh8000, 16'sh7fff);
		send_item(MODE_LOAD, 16'sd0, 16'sd1234);   // duplicate angle keeps load order
		send_item(MODE_QUERY, 16'sd0, 16'sd0);
		send_item(MODE_QUERY, 16'sh7fff, 16'sd0);
		send_item(MODE_QUERY, 16'sh8000, 16'sd0);
		send_item(MODE_QUERY, 16'sh7ffe, 16'sd0);
		send_item(MODE_QUERY, 16'sh8001, 16'sd0);
		send_item(MODE_QUERY, 16'sh4000, 16'sd0);
		send_item(MODE_QUERY, -16'sd12345, 16'sd0);
		drain();

		// receiver holds off while the sender keeps offering
		hold_off = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				hold_off = 1'b0;
			end
			begin
				for (int i = 0; i < 4; i++)
					send_item(MODE_QUERY, 16'($urandom), 16'($urandom));
				in_ch.valid <= 1'b0;
			end
		join

		// random: fill to full and beyond, with queries mixed in
		n = 0;
		while (n < 400) begin
			calm = (n >= 150 && n < 200);
			if ($urandom_range(99) < 45)
				send_item(MODE_LOAD, pick_angle(), 16'($urandom));
			else
				send_item(MODE_QUERY, pick_angle(), 16'($urandom));
			n++;
		end
		calm = 1'b0;
		drain();
		repeat (100) @(posedge clk);

		$display("covered %0d loads and %0d queries, %0d of them interpolated",
			board.loads, board.queries, board.interps);
		$display("table held %0d breakpoints at the end", board.angles.size());
		if (board.errors == 0 && board.owed.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
